@@ sv/u2d_pkg.sv @@
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared types and constants for the unsigned to digit string converter.
// ----------------------------------------------------------------------------
package u2d_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int VALUE_FIELD_W  = 32;
  localparam int RADIX_W        = 5;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 4;
  localparam int SHIFT_W        = 3;

  // divider: bits retired per cycle, padded working width
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES     = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int WORK_W         = DIV_CYCLES * BITS_PER_CYCLE;

  localparam int MAX_DIGITS     = VALUE_WIDTH;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE = 7'h39;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_F    = 7'h46;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef struct packed {
    logic [WORK_W-1:0]  value;
    logic [RADIX_W-1:0] radix;
    logic               pow2;
    logic [SHIFT_W-1:0] shift;
  } job_t;

endpackage

@@ sv/u2d_if.sv @@
// ----------------------------------------------------------------------------
// u2d_if
// Valid/ready channels: input word (value, radix) and output word (char, last).
// ----------------------------------------------------------------------------
interface u2d_in_if;
  logic                                valid;
  logic                                ready;
  logic [u2d_pkg::VALUE_FIELD_W-1:0]   value;
  logic [u2d_pkg::RADIX_W-1:0]         radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface u2d_out_if;
  logic                          valid;
  logic                          ready;
  logic [u2d_pkg::CHAR_W-1:0]    digit_char;
  logic                          last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

@@ sv/unsigned_to_digit_string.sv @@
// Division: 8 quotient bits per cycle for a non-power-of-two radix, a shift
// per digit for radix 2, 4, 8 or 16.
// Output: one char per cycle while out.ready holds; the divide/emit engine
// handles one word at a time.
// Reset: synchronous, clears the job queue, engine state and output valid.
// ----------------------------------------------------------------------------
// unsigned_to_digit_string
// Converts an unsigned value to upper-case ASCII digits in radix 2..16.
// ----------------------------------------------------------------------------
module unsigned_to_digit_string (
  input  logic       clk,
  input  logic       rst,
  u2d_in_if.sink     in,
  u2d_out_if.source  out
);

  u2d_pkg::job_t push_job;
  u2d_pkg::job_t pop_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  u2d_front u_front (
    .in   (in),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  u2d_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  u2d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .out     (out)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue underflow");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> ((out.digit_char >= u2d_pkg::CHAR_ZERO &&
                    out.digit_char <= u2d_pkg::CHAR_NINE) ||
                   (out.digit_char >= u2d_pkg::CHAR_A &&
                    out.digit_char <= u2d_pkg::CHAR_F)))
    else $error("output char outside digit set");
`endif

endmodule

@@ sv/u2d_front.sv @@
// ----------------------------------------------------------------------------
// u2d_front
// Accepts input words, clamps the radix and flags power-of-two radices.
// ----------------------------------------------------------------------------
module u2d_front (
  u2d_in_if.sink          in,
  input  logic            full,
  output logic            push,
  output u2d_pkg::job_t   job
);

  logic [u2d_pkg::RADIX_W-1:0] radix_c;

  always_comb begin
    if (in.radix > u2d_pkg::RADIX_MAX) begin
      radix_c = u2d_pkg::RADIX_MAX;
    end else if (in.radix < u2d_pkg::RADIX_MIN) begin
      radix_c = u2d_pkg::RADIX_MIN;
    end else begin
      radix_c = in.radix;
    end
  end

  always_comb begin
    job.value = u2d_pkg::WORK_W'(in.value[u2d_pkg::VALUE_WIDTH-1:0]);
    job.radix = radix_c;
    unique case (radix_c)
      5'd2: begin
        job.pow2  = 1'b1;
        job.shift = 3'd1;
      end
      5'd4: begin
        job.pow2  = 1'b1;
        job.shift = 3'd2;
      end
      5'd8: begin
        job.pow2  = 1'b1;
        job.shift = 3'd3;
      end
      5'd16: begin
        job.pow2  = 1'b1;
        job.shift = 3'd4;
      end
      default: begin
        job.pow2  = 1'b0;
        job.shift = 3'd0;
      end
    endcase
  end

  assign in.ready = !full;
  assign push     = in.valid && !full;

endmodule

@@ sv/u2d_fifo.sv @@
// ----------------------------------------------------------------------------
// u2d_fifo
// Short job queue between the front and the digit engine.
// ----------------------------------------------------------------------------
module u2d_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u2d_pkg::job_t   push_job,
  input  logic            pop,
  output u2d_pkg::job_t   pop_job,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (u2d_pkg::FIFO_DEPTH > 1) ? $clog2(u2d_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(u2d_pkg::FIFO_DEPTH + 1);

  u2d_pkg::job_t     entries [u2d_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(u2d_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full    = (count == CNT_W'(u2d_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/u2d_back.sv @@
// ----------------------------------------------------------------------------
// u2d_back
// Digit engine: divides by the radix (8 quotient bits per cycle, or a shift
// for power-of-two radices), stacks digits, then emits them MSB first.
// ----------------------------------------------------------------------------
module u2d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  u2d_pkg::job_t   pop_job,
  output logic            pop,
  u2d_out_if.source       out
);

  localparam int IDX_W = $clog2(u2d_pkg::MAX_DIGITS);
  localparam int SP_W  = $clog2(u2d_pkg::MAX_DIGITS + 1);
  localparam int CNT_W = $clog2(u2d_pkg::DIV_CYCLES + 1);
  localparam int BPC   = u2d_pkg::BITS_PER_CYCLE;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                        state;
  logic [u2d_pkg::WORK_W-1:0]        w;
  logic [u2d_pkg::RADIX_W-1:0]       rdx;
  logic                              pow2;
  logic [u2d_pkg::SHIFT_W-1:0]       shamt;
  logic [u2d_pkg::DIGIT_W-1:0]       rem;
  logic [CNT_W-1:0]                  cnt;
  logic [SP_W-1:0]                   sp;
  logic [u2d_pkg::DIGIT_W-1:0]       stack [u2d_pkg::MAX_DIGITS];
  logic                              out_valid;
  logic [u2d_pkg::CHAR_W-1:0]        out_char;
  logic                              out_last;

  logic [u2d_pkg::DIGIT_W-1:0]       rem_next;
  logic [BPC-1:0]                    qbits;
  logic [u2d_pkg::RADIX_W-1:0]       trial;
  logic [u2d_pkg::WORK_W-1:0]        quot_w;
  logic [u2d_pkg::WORK_W-1:0]        shift_w;
  logic [u2d_pkg::DIGIT_W-1:0]       shift_digit;
  logic                              div_last;
  logic                              emit_go;
  logic [u2d_pkg::DIGIT_W-1:0]       top_digit;
  logic [SP_W-1:0]                   sp_m1;

  function automatic logic [u2d_pkg::CHAR_W-1:0] to_ascii(
    input logic [u2d_pkg::DIGIT_W-1:0] d
  );
    if (d < u2d_pkg::DIGIT_TEN) begin
      return u2d_pkg::CHAR_ZERO + u2d_pkg::CHAR_W'(d);
    end
    return u2d_pkg::CHAR_A + u2d_pkg::CHAR_W'(d - u2d_pkg::DIGIT_TEN);
  endfunction

  // restoring division, one quotient bit per step, remainder stays below 16
  always_comb begin
    rem_next = rem;
    trial    = '0;
    qbits    = '0;
    for (int i = 0; i < BPC; i++) begin
      trial = {rem_next, w[u2d_pkg::WORK_W-1-i]};
      if (trial >= rdx) begin
        qbits[BPC-1-i] = 1'b1;
        rem_next       = u2d_pkg::DIGIT_W'(trial - rdx);
      end else begin
        rem_next       = trial[u2d_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign quot_w      = (w << BPC) | u2d_pkg::WORK_W'(qbits);
  assign shift_w     = w >> shamt;
  assign shift_digit = w[u2d_pkg::DIGIT_W-1:0] & (rdx[u2d_pkg::DIGIT_W-1:0] - 4'd1);
  assign div_last    = (cnt == CNT_W'(u2d_pkg::DIV_CYCLES - 1));

  assign sp_m1     = sp - SP_W'(1);
  assign top_digit = stack[sp_m1[IDX_W-1:0]];
  assign emit_go   = !out_valid || out.ready;

  assign pop            = (state == ST_IDLE) && !empty;
  assign out.valid      = out_valid;
  assign out.digit_char = out_char;
  assign out.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            w     <= pop_job.value;
            rdx   <= pop_job.radix;
            pow2  <= pop_job.pow2;
            shamt <= pop_job.shift;
            rem   <= '0;
            cnt   <= '0;
            sp    <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (pow2) begin
            stack[sp[IDX_W-1:0]] <= shift_digit;
            sp                   <= sp + SP_W'(1);
            w                    <= shift_w;
            if (shift_w == '0) begin
              state <= ST_EMIT;
            end
          end else begin
            w <= quot_w;
            if (div_last) begin
              stack[sp[IDX_W-1:0]] <= rem_next;
              sp                   <= sp + SP_W'(1);
              rem                  <= '0;
              cnt                  <= '0;
              if (quot_w == '0) begin
                state <= ST_EMIT;
              end
            end else begin
              rem <= rem_next;
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            out_char  <= to_ascii(top_digit);
            out_last  <= (sp == SP_W'(1));
            sp        <= sp_m1;
            if (sp == SP_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
